// ----- rtl/cis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cis_pkg
// Types, codes and the fixed interference weight table of the channel
// interference selector.
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam int TABLE_CH  = 11;
  localparam int TOTAL_W   = 16;
  localparam int CHAN_W    = 8;
  localparam int RSSI_W    = 8;
  localparam int BEST_W    = 4;
  localparam int ROW_W     = 4;
  localparam int WEIGHT_W  = 3;
  localparam int TREE_N    = 16;
  localparam int TREE_LVLS = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic signed [RSSI_W-1:0] THRESHOLD_RESET = -8'sd70;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic REG_RSSI_THRESHOLD = 1'b0;

  localparam logic TBL_WEAK   = 1'b0;
  localparam logic TBL_STRONG = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [CHAN_W-1:0]        channel;
    logic signed [RSSI_W-1:0] rssi;
  } in_word_t;

  typedef struct packed {
    logic [BEST_W-1:0]  best_channel;
    logic [TOTAL_W-1:0] best_total;
  } out_word_t;

  // strong row for channel 7 ends in 0, kept as specified
  localparam logic [WEIGHT_W-1:0] WEIGHTS [0:1][0:TABLE_CH-1][0:TABLE_CH-1] = '{
    '{
      '{3, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0},
      '{2, 3, 2, 1, 0, 0, 0, 0, 0, 0, 0},
      '{1, 2, 3, 2, 1, 0, 0, 0, 0, 0, 0},
      '{0, 1, 2, 3, 2, 1, 0, 0, 0, 0, 0},
      '{0, 0, 1, 2, 3, 2, 1, 0, 0, 0, 0},
      '{0, 0, 0, 1, 2, 3, 2, 1, 0, 0, 0},
      '{0, 0, 0, 0, 1, 2, 3, 2, 1, 0, 0},
      '{0, 0, 0, 0, 0, 1, 2, 3, 2, 1, 0},
      '{0, 0, 0, 0, 0, 0, 1, 2, 3, 2, 1},
      '{0, 0, 0, 0, 0, 0, 0, 1, 2, 3, 2},
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 3}
    },
    '{
      '{5, 4, 3, 2, 1, 0, 0, 0, 0, 0, 0},
      '{4, 5, 4, 3, 2, 1, 0, 0, 0, 0, 0},
      '{3, 4, 5, 4, 3, 2, 1, 0, 0, 0, 0},
      '{2, 3, 4, 5, 4, 3, 2, 1, 0, 0, 0},
      '{1, 2, 3, 4, 5, 4, 3, 2, 1, 0, 0},
      '{0, 1, 2, 3, 4, 5, 4, 3, 2, 1, 0},
      '{0, 0, 1, 2, 3, 4, 5, 4, 3, 2, 0},
      '{0, 0, 0, 1, 2, 3, 4, 5, 4, 3, 2},
      '{0, 0, 0, 0, 1, 2, 3, 4, 5, 4, 3},
      '{0, 0, 0, 0, 0, 1, 2, 3, 4, 5, 4},
      '{0, 0, 0, 0, 0, 0, 1, 2, 3, 4, 5}
    }
  };

endpackage

// ----- rtl/channel_interference_selector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_interference_selector
// Accumulates per-channel interference weights from scan observations and
// reports the least loaded channel after every word.
// ----------------------------------------------------------------------------
// Takes one scan word per clock while out_ready is high and gives one result
// word per input word via the input register, then the result register. The
// one-cycle rate is set by the stage that adds a weight row to all channel
// totals with saturation and runs the 16-leaf minimum tree in the same cycle.
// Both sides stall independently; the input register and result register
// keep full throughput while out_ready stays high. rssi_threshold is written
// through the APB port at address 0 and should be changed only while idle.
// ----------------------------------------------------------------------------
module channel_interference_selector #(
  parameter int NUM_CHANNELS = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cis_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cis_pkg::out_word_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int TW = cis_pkg::TOTAL_W;

  logic                                   in_valid_r;
  cis_pkg::in_word_t                      in_r;
  logic                                   out_valid_r;
  cis_pkg::out_word_t                     out_r;
  cis_pkg::out_word_t                     out_nxt;
  logic [NUM_CHANNELS-1:0][TW-1:0]        totals_r;
  logic [NUM_CHANNELS-1:0][TW-1:0]        totals_nxt;
  logic signed [cis_pkg::RSSI_W-1:0]      thr_r;
  logic                                   advance;
  logic                                   row_hit;
  logic                                   tbl_sel;
  logic [cis_pkg::ROW_W-1:0]              row;
  logic [TW:0]                            sum;
  logic [TW-1:0]                          lv_val [0:cis_pkg::TREE_LVLS][0:cis_pkg::TREE_N-1];
  logic [cis_pkg::BEST_W-1:0]             lv_idx [0:cis_pkg::TREE_LVLS][0:cis_pkg::TREE_N-1];

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cis_pkg::REG_RSSI_THRESHOLD) ? {24'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= cis_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == cis_pkg::REG_RSSI_THRESHOLD) begin
      thr_r <= pwdata[cis_pkg::RSSI_W-1:0];
    end
  end

  // flow control
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // totals update
  assign row_hit = (in_r.channel >= cis_pkg::CHAN_W'(1)) &&
                   (in_r.channel <= cis_pkg::CHAN_W'(cis_pkg::TABLE_CH));
  assign tbl_sel = (in_r.rssi < thr_r) ? cis_pkg::TBL_WEAK : cis_pkg::TBL_STRONG;
  assign row     = in_r.channel[cis_pkg::ROW_W-1:0] - cis_pkg::ROW_W'(1);

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      unique case (in_r.action)
        cis_pkg::ACT_CLEAR: begin
          totals_nxt[i] = '0;
        end
        cis_pkg::ACT_ADD: begin
          if (row_hit) begin
            sum = {1'b0, totals_r[i]} +
                  (TW+1)'(cis_pkg::WEIGHTS[tbl_sel][row][i]);
            totals_nxt[i] = sum[TW] ? cis_pkg::TOTAL_MAX : sum[TW-1:0];
          end else begin
            totals_nxt[i] = totals_r[i];
          end
        end
        default: totals_nxt[i] = totals_r[i];
      endcase
    end
  end

  // minimum tree, left wins on ties; pads sit right of every real channel
  always_comb begin
    for (int l = 0; l <= cis_pkg::TREE_LVLS; l++) begin
      for (int j = 0; j < cis_pkg::TREE_N; j++) begin
        lv_val[l][j] = cis_pkg::TOTAL_MAX;
        lv_idx[l][j] = cis_pkg::BEST_W'(j);
      end
    end
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      lv_val[0][j] = totals_nxt[j];
    end
    for (int l = 0; l < cis_pkg::TREE_LVLS; l++) begin
      for (int j = 0; j < (cis_pkg::TREE_N >> (l + 1)); j++) begin
        if (lv_val[l][2*j+1] < lv_val[l][2*j]) begin
          lv_val[l+1][j] = lv_val[l][2*j+1];
          lv_idx[l+1][j] = lv_idx[l][2*j+1];
        end else begin
          lv_val[l+1][j] = lv_val[l][2*j];
          lv_idx[l+1][j] = lv_idx[l][2*j];
        end
      end
    end
    out_nxt.best_channel = lv_idx[cis_pkg::TREE_LVLS][0] + cis_pkg::BEST_W'(1);
    out_nxt.best_total   = lv_val[cis_pkg::TREE_LVLS][0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      totals_r <= '0;
    end else if (advance) begin
      totals_r <= totals_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // checks
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_r.action == cis_pkg::ACT_CLEAR |=>
      out_r.best_channel == cis_pkg::BEST_W'(1) && out_r.best_total == '0)
    else $error("clear did not give channel 1 with total 0");

  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.best_channel >= cis_pkg::BEST_W'(1) &&
                    out_r.best_channel <= cis_pkg::BEST_W'(NUM_CHANNELS))
    else $error("best channel out of range");

  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(totals_r))
    else $error("totals changed without a word");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_r))
    else $error("input stage overwritten while stalled");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for channel_interference_selector. Result words are
// predicted by a channel load model that keeps its own totals and threshold.
// Traffic covers directed corner words, several threshold settings, random
// traffic with bursty sending and stalls on the result side, and a soak
// that raises every total evenly.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_CH         = 11;
  localparam int SEARCH_N       = (NUM_CH > cis_pkg::TABLE_CH) ? cis_pkg::TABLE_CH :
                                  ((NUM_CH < 1) ? 1 : NUM_CH);
  localparam int RESULT_LATENCY = 2;
  localparam int IDLE_LIMIT     = 2000;
  localparam int HOLD_CYCLES    = 120;
  localparam int PHASE_WORDS    = 70;
  localparam int SOAK_TRIPLES   = 20;

  localparam logic [2:0] ADDR_THRESHOLD = 3'(cis_pkg::REG_RSSI_THRESHOLD) << 2;
  localparam logic [2:0] ADDR_UNUSED    = 3'd4;

  class channel_load_model;
    logic [cis_pkg::TOTAL_W-1:0]       load [cis_pkg::TABLE_CH];
    logic signed [cis_pkg::RSSI_W-1:0] threshold;
    cis_pkg::out_word_t                pending_best [$];
    int unsigned                       errors;

    function new();
      clear_load();
      threshold = cis_pkg::THRESHOLD_RESET;
      errors = 0;
    endfunction

    function void clear_load();
      for (int i = 0; i < cis_pkg::TABLE_CH; i++) load[i] = '0;
    endfunction

    // triangular rows; strong row of channel 7 has a zero in its last column
    function int unsigned weight(logic tbl, int row, int col);
      int d;
      int peak;
      int w;
      d = (row > col) ? row - col : col - row;
      peak = (tbl == cis_pkg::TBL_STRONG) ? 5 : 3;
      w = (d >= peak) ? 0 : peak - d;
      if (tbl == cis_pkg::TBL_STRONG && row == 6 && col == 10) w = 0;
      return w;
    endfunction

    function void note_scan(cis_pkg::in_word_t w);
      logic [cis_pkg::TOTAL_W:0] sum;
      logic                      tbl;
      int                        best;
      cis_pkg::out_word_t        r;
      if (w.action == cis_pkg::ACT_CLEAR) begin
        clear_load();
      end else if (w.channel >= 1 && w.channel <= cis_pkg::TABLE_CH) begin
        tbl = ($signed(w.rssi) < $signed(threshold)) ? cis_pkg::TBL_WEAK :
                                                        cis_pkg::TBL_STRONG;
        for (int i = 0; i < cis_pkg::TABLE_CH; i++) begin
          sum = {1'b0, load[i]} +
                (cis_pkg::TOTAL_W+1)'(weight(tbl, int'(w.channel) - 1, i));
          load[i] = (sum > cis_pkg::TOTAL_MAX) ? cis_pkg::TOTAL_MAX :
                                                  sum[cis_pkg::TOTAL_W-1:0];
        end
      end
      best = 0;
      for (int i = 1; i < SEARCH_N; i++) begin
        if (load[i] < load[best]) best = i;
      end
      r.best_channel = cis_pkg::BEST_W'(best + 1);
      r.best_total = load[best];
      pending_best.push_back(r);
    endfunction

    function void check_best(cis_pkg::out_word_t got);
      cis_pkg::out_word_t exp;
      if (pending_best.size() == 0) begin
        $display("%0t: unexpected result word ch %0d total %0d", $time,
                 got.best_channel, got.best_total);
        errors++;
        return;
      end
      exp = pending_best.pop_front();
      if (got.best_channel !== exp.best_channel) begin
        $display("%0t: best_channel expected %0d actual %0d", $time,
                 exp.best_channel, got.best_channel);
        errors++;
      end
      if (got.best_total !== exp.best_total) begin
        $display("%0t: best_total expected %0d actual %0d", $time,
                 exp.best_total, got.best_total);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  cis_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  cis_pkg::out_word_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  channel_load_model board;
  logic              rx_hold_req;
  int                idle_cycles;
  int                burst_left;

  channel_interference_selector #(
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_best(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results pending", $time, board.pending_best.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: stall pattern switches at random among four modes
  initial begin
    int mode;
    int mode_left;
    int cyc;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (cyc % 4) != 3;
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic cis_pkg::in_word_t make_scan(logic act, int ch, int rssi);
    cis_pkg::in_word_t w;
    w.action = act;
    w.channel = cis_pkg::CHAN_W'(ch);
    w.rssi = cis_pkg::RSSI_W'(rssi);
    return w;
  endfunction

  function automatic cis_pkg::in_word_t rand_scan(int thr);
    cis_pkg::in_word_t w;
    int                sel;
    int                v;
    w.action = ($urandom_range(0, 19) == 0) ? cis_pkg::ACT_CLEAR : cis_pkg::ACT_ADD;
    sel = $urandom_range(0, 9);
    if (sel < 8) w.channel = cis_pkg::CHAN_W'($urandom_range(1, cis_pkg::TABLE_CH));
    else if (sel == 8) w.channel = ($urandom_range(0, 1) == 0) ? '0 :
                                   cis_pkg::CHAN_W'($urandom_range(12, 15));
    else w.channel = cis_pkg::CHAN_W'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      w.rssi = cis_pkg::RSSI_W'($urandom());
    end else begin
      v = thr + int'($urandom_range(0, 4)) - 2;
      if (v < -128) v = -128;
      if (v > 127) v = 127;
      w.rssi = cis_pkg::RSSI_W'(v);
    end
    return w;
  endfunction

  task automatic send_scan(cis_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    board.note_scan(w);
    @(negedge clk);
  endtask

  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending_best.size() > 0) @(negedge clk);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_read_check(logic [2:0] addr, logic [cis_pkg::RSSI_W-1:0] exp);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[cis_pkg::RSSI_W-1:0] !== exp) begin
      $display("%0t: rssi_threshold readback expected %0h actual %0h", $time,
               exp, prdata[cis_pkg::RSSI_W-1:0]);
      board.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_threshold(int thr);
    drain_results();
    apb_write(ADDR_THRESHOLD, 32'(thr));
    board.threshold = cis_pkg::RSSI_W'(thr);
    apb_read_check(ADDR_THRESHOLD, cis_pkg::RSSI_W'(thr));
  endtask

  initial begin
    int thr;
    board = new();
    rx_hold_req = 1'b0;
    idle_cycles = 0;
    burst_left = 1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apb_read_check(ADDR_THRESHOLD, cis_pkg::THRESHOLD_RESET);

    // directed words at the reset threshold
    send_scan(make_scan(cis_pkg::ACT_CLEAR, 0, 0));                pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 1, -71));                pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 1, -70));                pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 11, 127));               pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 11, -128));              pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 0, 127));                pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 12, 0));                 pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 255, -1));               pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 7, 0));                  pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 7, -100));               pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 6, -69));                pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 8'hAA, 8'h55));          pace();
    send_scan(make_scan(cis_pkg::ACT_CLEAR, 8'hFF, 127));          pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 4, 8'h80));              pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 10, 8'h7F));             pace();
    send_scan(make_scan(cis_pkg::ACT_CLEAR, 8'h55, 8'hAA));        pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 2, 5));                  pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 9, -80));                pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 3, -70));                pace();
    send_scan(make_scan(cis_pkg::ACT_ADD, 5, 1));                  pace();

    // write to an address past the only register must not land
    drain_results();
    apb_write(ADDR_UNUSED, 32'h7F);
    apb_read_check(ADDR_THRESHOLD, cis_pkg::THRESHOLD_RESET);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: thr = -128;
        1: thr = 127;
        2: thr = 0;
        3: thr = int'($urandom_range(0, 255)) - 128;
        default: thr = -70;
      endcase
      set_threshold(thr);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 0 && n == 20) rx_hold_req = 1'b1;
        if (phase == 2 && n == 45) drain_results();
        send_scan(rand_scan(thr));
        if (phase == 0 && n >= 20 && n < 40) continue;
        pace();
      end
    end

    // soak: channels 1, 6 and 11 strong add 5 to every total
    set_threshold(0);
    send_scan(make_scan(cis_pkg::ACT_CLEAR, 0, 0));
    for (int n = 0; n < SOAK_TRIPLES; n++) begin
      send_scan(make_scan(cis_pkg::ACT_ADD, 1, 127));
      send_scan(make_scan(cis_pkg::ACT_ADD, 6, 127));
      send_scan(make_scan(cis_pkg::ACT_ADD, 11, 127));
    end
    for (int n = 0; n < 20; n++) begin
      send_scan(rand_scan(0));
      pace();
    end
    send_scan(make_scan(cis_pkg::ACT_CLEAR, 0, 0));

    drain_results();
    repeat (4 * RESULT_LATENCY) @(negedge clk);
    if (board.errors == 0 && board.pending_best.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
